// ===== design/ipbf_pkg.sv =====
package ipbf_pkg;

  // Table sizes and the address widths that follow from them.
  localparam int unsigned LISTENER_SLOTS = 64;
  localparam int unsigned RULE_SLOTS     = 256;
  localparam int unsigned LST_AW  = (LISTENER_SLOTS > 1) ? $clog2(LISTENER_SLOTS) : 1;
  localparam int unsigned RULE_AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CLR_SLOTS = (LISTENER_SLOTS > RULE_SLOTS) ? LISTENER_SLOTS
                                                                    : RULE_SLOTS;
  localparam int unsigned CLR_AW  = (CLR_SLOTS > 1) ? $clog2(CLR_SLOTS) : 1;

  // Input beat kinds.
  localparam logic [1:0] MODE_FRAME    = 2'd0;
  localparam logic [1:0] MODE_LISTENER = 2'd1;
  localparam logic [1:0] MODE_RULE     = 2'd2;

  // Verdict causes.
  localparam logic [2:0] CAUSE_TRUNCATED   = 3'd0;
  localparam logic [2:0] CAUSE_NOT_IPV4    = 3'd1;
  localparam logic [2:0] CAUSE_OTHER_PROTO = 3'd2;
  localparam logic [2:0] CAUSE_NO_LISTENER = 3'd3;
  localparam logic [2:0] CAUSE_LISTED_DROP = 3'd4;
  localparam logic [2:0] CAUSE_NOT_LISTED  = 3'd5;

  // Protocol constants.
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  // Byte positions of the captured header fields.
  localparam logic [5:0] POS_ETH_HI   = 6'd12;
  localparam logic [5:0] POS_ETH_LO   = 6'd13;
  localparam logic [5:0] POS_PROTO    = 6'd23;
  localparam logic [5:0] POS_SRC_B3   = 6'd26;
  localparam logic [5:0] POS_SRC_B2   = 6'd27;
  localparam logic [5:0] POS_SRC_B1   = 6'd28;
  localparam logic [5:0] POS_SRC_B0   = 6'd29;
  localparam logic [5:0] POS_PORT_HI  = 6'd36;
  localparam logic [5:0] POS_PORT_LO  = 6'd37;

  // Minimum frame lengths.
  localparam logic [5:0] LEN_ETH   = 6'd14;
  localparam logic [5:0] LEN_IP    = 6'd34;
  localparam logic [5:0] LEN_TCP   = 6'd54;
  localparam logic [5:0] LEN_UDP   = 6'd42;
  localparam logic [5:0] COUNT_MAX = 6'd63;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [7:0]  slot;
    logic        entry_valid;
    logic [31:0] entry_addr;
    logic [15:0] entry_port;
    logic [7:0]  entry_action;
  } in_item_t;

  typedef struct packed {
    logic        drop;
    logic [2:0]  cause;
    logic [31:0] src_addr;
    logic [15:0] dst_port;
  } out_item_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] port;
  } lst_word_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  action;
    logic [15:0] port;
    logic [31:0] addr;
  } rule_word_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_EVAL,
    ST_LSCAN,
    ST_RSCAN
  } state_t;

  typedef enum logic [1:0] {
    RES_PRE,
    RES_NOLST,
    RES_RULE_HIT,
    RES_RULE_MISS
  } res_sel_t;

  typedef struct packed {
    logic     accept;
    logic     frame_clr;
    logic     scan_clr;
    logic     l_scan;
    logic     r_scan;
    logic     clr_step;
    logic     out_load;
    res_sel_t res_sel;
  } ctl_cmd_t;

  typedef struct packed {
    logic last_byte;
    logic pre_done;
    logic lst_match;
    logic lst_end;
    logic rule_match;
    logic rule_end;
    logic clr_done;
  } ctl_stat_t;

endpackage

// ===== design/ipv4_port_blacklist_filter.sv =====
// IPv4 port blacklist filter. Frame bytes and table writes arrive as beats on the
// in_ channel, one per cycle while the block is idle; a table write takes effect
// at once. A frame's last byte starts its verdict: the evaluation state settles
// short, non-IPv4 and non-TCP/UDP frames; otherwise the listener table is swept
// through its single read port, one slot a cycle, and on a listener hit the rule
// table likewise, stopping at the lowest matching slot. Evaluation waits for
// the previous verdict to leave the output register. The verdict waits in that
// register, and byte and write beats of the next frame are taken meanwhile. After
// reset a clearing pass over all max(LISTENER_SLOTS, RULE_SLOTS) slot addresses
// empties both tables before the first beat is taken.
module ipv4_port_blacklist_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipbf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ipbf_pkg::out_item_t out_data
);

  ipbf_pkg::ctl_cmd_t  cmd;
  ipbf_pkg::ctl_stat_t stat;

  // Sequencing of parse, evaluation, sweeps and the result handshake.
  ipbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Header capture, tables, comparators and the result register.
  ipbf_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

// ===== design/ipbf_datapath.sv =====
module ipbf_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  ipbf_pkg::in_item_t in_data,
  input  ipbf_pkg::ctl_cmd_t cmd,
  output ipbf_pkg::ctl_stat_t stat,
  output ipbf_pkg::out_item_t out_data
);

  localparam logic [ipbf_pkg::LST_AW-1:0]  L_LAST =
    ipbf_pkg::LST_AW'(ipbf_pkg::LISTENER_SLOTS - 1);
  localparam logic [ipbf_pkg::RULE_AW-1:0] R_LAST =
    ipbf_pkg::RULE_AW'(ipbf_pkg::RULE_SLOTS - 1);
  localparam logic [ipbf_pkg::CLR_AW-1:0]  C_LAST =
    ipbf_pkg::CLR_AW'(ipbf_pkg::CLR_SLOTS - 1);

  // Frame parse registers.
  logic [5:0]  byte_count_r, byte_count_nxt;
  logic [15:0] ethertype_r, ethertype_nxt;
  logic [7:0]  protocol_r, protocol_nxt;
  logic [31:0] source_r, source_nxt;
  logic [15:0] port_r, port_nxt;

  // Table memories and their read stages.
  ipbf_pkg::lst_word_t  lst_mem [ipbf_pkg::LISTENER_SLOTS];
  ipbf_pkg::rule_word_t rule_mem [ipbf_pkg::RULE_SLOTS];
  ipbf_pkg::lst_word_t  lst_q_r;
  ipbf_pkg::rule_word_t rule_q_r;
  logic                 lrd_vld_r, lrd_last_r, rrd_vld_r, rrd_last_r;
  logic [ipbf_pkg::LST_AW-1:0]  l_idx_r, l_idx_nxt;
  logic [ipbf_pkg::RULE_AW-1:0] r_idx_r, r_idx_nxt;
  logic [ipbf_pkg::CLR_AW-1:0]  clr_idx_r, clr_idx_nxt;

  // Memory write ports.
  logic                         lst_we, rule_we;
  logic [ipbf_pkg::LST_AW-1:0]  lst_wa;
  logic [ipbf_pkg::RULE_AW-1:0] rule_wa;
  ipbf_pkg::lst_word_t          lst_wd;
  ipbf_pkg::rule_word_t         rule_wd;

  // Early verdict and output register.
  logic                 pre_done;
  logic [2:0]           pre_cause;
  logic [31:0]          pre_addr;
  logic                 is_tcp, is_udp, rule_drop;
  ipbf_pkg::out_item_t  out_r, out_nxt;

  // Byte counting and header capture.
  always_comb begin
    byte_count_nxt = byte_count_r;
    ethertype_nxt  = ethertype_r;
    protocol_nxt   = protocol_r;
    source_nxt     = source_r;
    port_nxt       = port_r;
    if (cmd.frame_clr) begin
      byte_count_nxt = '0;
      ethertype_nxt  = '0;
      protocol_nxt   = '0;
      source_nxt     = '0;
      port_nxt       = '0;
    end else if (cmd.accept && in_data.mode == ipbf_pkg::MODE_FRAME) begin
      byte_count_nxt = (byte_count_r == ipbf_pkg::COUNT_MAX) ? ipbf_pkg::COUNT_MAX
                                                             : byte_count_r + 6'd1;
      case (byte_count_r)
        ipbf_pkg::POS_ETH_HI:  ethertype_nxt[15:8] = in_data.frame_byte;
        ipbf_pkg::POS_ETH_LO:  ethertype_nxt[7:0]  = in_data.frame_byte;
        ipbf_pkg::POS_PROTO:   protocol_nxt        = in_data.frame_byte;
        ipbf_pkg::POS_SRC_B3:  source_nxt[31:24]   = in_data.frame_byte;
        ipbf_pkg::POS_SRC_B2:  source_nxt[23:16]   = in_data.frame_byte;
        ipbf_pkg::POS_SRC_B1:  source_nxt[15:8]    = in_data.frame_byte;
        ipbf_pkg::POS_SRC_B0:  source_nxt[7:0]     = in_data.frame_byte;
        ipbf_pkg::POS_PORT_HI: port_nxt[15:8]      = in_data.frame_byte;
        ipbf_pkg::POS_PORT_LO: port_nxt[7:0]       = in_data.frame_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      ethertype_r  <= '0;
      protocol_r   <= '0;
      source_r     <= '0;
      port_r       <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      ethertype_r  <= ethertype_nxt;
      protocol_r   <= protocol_nxt;
      source_r     <= source_nxt;
      port_r       <= port_nxt;
    end
  end

  // Table write selection: the clearing pass after reset, else table-write beats.
  always_comb begin
    lst_we  = 1'b0;
    rule_we = 1'b0;
    lst_wa  = ipbf_pkg::LST_AW'(in_data.slot);
    rule_wa = ipbf_pkg::RULE_AW'(in_data.slot);
    lst_wd  = '{valid: in_data.entry_valid, port: in_data.entry_port};
    rule_wd = '{valid: in_data.entry_valid, action: in_data.entry_action,
                port: in_data.entry_port, addr: in_data.entry_addr};
    if (cmd.clr_step) begin
      lst_wa  = ipbf_pkg::LST_AW'(clr_idx_r);
      rule_wa = ipbf_pkg::RULE_AW'(clr_idx_r);
      lst_wd  = '0;
      rule_wd = '0;
      lst_we  = 32'(clr_idx_r) < ipbf_pkg::LISTENER_SLOTS;
      rule_we = 32'(clr_idx_r) < ipbf_pkg::RULE_SLOTS;
    end else if (cmd.accept) begin
      lst_we  = in_data.mode == ipbf_pkg::MODE_LISTENER &&
                32'(in_data.slot) < ipbf_pkg::LISTENER_SLOTS;
      rule_we = in_data.mode == ipbf_pkg::MODE_RULE &&
                32'(in_data.slot) < ipbf_pkg::RULE_SLOTS;
    end
  end

  // Listener memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (lst_we) begin
      lst_mem[lst_wa] <= lst_wd;
    end
    if (cmd.l_scan) begin
      lst_q_r <= lst_mem[l_idx_r];
    end
  end

  // Rule memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (rule_we) begin
      rule_mem[rule_wa] <= rule_wd;
    end
    if (cmd.r_scan) begin
      rule_q_r <= rule_mem[r_idx_r];
    end
  end

  // Sweep and clearing counters.
  always_comb begin
    l_idx_nxt   = l_idx_r;
    r_idx_nxt   = r_idx_r;
    clr_idx_nxt = clr_idx_r;
    if (cmd.scan_clr) begin
      l_idx_nxt = '0;
      r_idx_nxt = '0;
    end else begin
      if (cmd.l_scan) begin
        l_idx_nxt = (l_idx_r == L_LAST) ? '0 : l_idx_r + 1'b1;
      end
      if (cmd.r_scan) begin
        r_idx_nxt = (r_idx_r == R_LAST) ? '0 : r_idx_r + 1'b1;
      end
    end
    if (cmd.clr_step) begin
      clr_idx_nxt = (clr_idx_r == C_LAST) ? '0 : clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_idx_r    <= '0;
      r_idx_r    <= '0;
      clr_idx_r  <= '0;
      lrd_vld_r  <= 1'b0;
      lrd_last_r <= 1'b0;
      rrd_vld_r  <= 1'b0;
      rrd_last_r <= 1'b0;
    end else begin
      l_idx_r    <= l_idx_nxt;
      r_idx_r    <= r_idx_nxt;
      clr_idx_r  <= clr_idx_nxt;
      lrd_vld_r  <= cmd.l_scan;
      lrd_last_r <= l_idx_r == L_LAST;
      rrd_vld_r  <= cmd.r_scan;
      rrd_last_r <= r_idx_r == R_LAST;
    end
  end

  // Verdicts that need no table lookup, from the length and the captured header.
  assign is_tcp = protocol_r == ipbf_pkg::PROTO_TCP;
  assign is_udp = protocol_r == ipbf_pkg::PROTO_UDP;

  always_comb begin
    pre_done  = 1'b1;
    pre_cause = ipbf_pkg::CAUSE_TRUNCATED;
    pre_addr  = '0;
    if (byte_count_r < ipbf_pkg::LEN_ETH) begin
      pre_cause = ipbf_pkg::CAUSE_TRUNCATED;
    end else if (ethertype_r != ipbf_pkg::ETHERTYPE_IPV4) begin
      pre_cause = ipbf_pkg::CAUSE_NOT_IPV4;
    end else if (byte_count_r < ipbf_pkg::LEN_IP) begin
      pre_cause = ipbf_pkg::CAUSE_TRUNCATED;
    end else begin
      pre_addr = source_r;
      if (is_tcp && byte_count_r < ipbf_pkg::LEN_TCP) begin
        pre_cause = ipbf_pkg::CAUSE_TRUNCATED;
      end else if (is_udp && byte_count_r < ipbf_pkg::LEN_UDP) begin
        pre_cause = ipbf_pkg::CAUSE_TRUNCATED;
      end else if (!is_tcp && !is_udp) begin
        pre_cause = ipbf_pkg::CAUSE_OTHER_PROTO;
      end else begin
        pre_done = 1'b0;
      end
    end
  end

  // Status towards the controller; each sweep compares one entry a cycle.
  always_comb begin
    stat.last_byte  = in_data.mode == ipbf_pkg::MODE_FRAME && in_data.frame_last;
    stat.pre_done   = pre_done;
    stat.lst_match  = lrd_vld_r && lst_q_r.valid && lst_q_r.port == port_r;
    stat.lst_end    = lrd_vld_r && lrd_last_r && !stat.lst_match;
    stat.rule_match = rrd_vld_r && rule_q_r.valid && rule_q_r.addr == source_r &&
                      rule_q_r.port == port_r;
    stat.rule_end   = rrd_vld_r && rrd_last_r && !stat.rule_match;
    stat.clr_done   = clr_idx_r == C_LAST;
  end

  // Result assembly into the output register.
  assign rule_drop = rule_q_r.action == 8'd0;

  always_comb begin
    out_nxt = out_r;
    if (cmd.out_load) begin
      case (cmd.res_sel)
        ipbf_pkg::RES_PRE: begin
          out_nxt = '{drop: 1'b0, cause: pre_cause, src_addr: pre_addr, dst_port: 16'd0};
        end
        ipbf_pkg::RES_NOLST: begin
          out_nxt = '{drop: 1'b0, cause: ipbf_pkg::CAUSE_NO_LISTENER,
                      src_addr: source_r, dst_port: port_r};
        end
        ipbf_pkg::RES_RULE_HIT: begin
          out_nxt = '{drop: rule_drop,
                      cause: rule_drop ? ipbf_pkg::CAUSE_LISTED_DROP
                                       : ipbf_pkg::CAUSE_NOT_LISTED,
                      src_addr: source_r, dst_port: port_r};
        end
        default: begin
          out_nxt = '{drop: 1'b0, cause: ipbf_pkg::CAUSE_NOT_LISTED,
                      src_addr: source_r, dst_port: port_r};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ===== design/ipbf_ctrl.sv =====
module ipbf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ipbf_pkg::ctl_stat_t stat,
  output ipbf_pkg::ctl_cmd_t  cmd
);

  ipbf_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  // Beats are taken whenever the block is idle; a pending verdict only holds evaluation.
  assign in_ready = state_r == ipbf_pkg::ST_IDLE;
  assign accept   = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ipbf_pkg::ST_CLR: begin
        if (stat.clr_done) state_nxt = ipbf_pkg::ST_IDLE;
      end
      ipbf_pkg::ST_IDLE: begin
        if (accept && stat.last_byte) state_nxt = ipbf_pkg::ST_EVAL;
      end
      ipbf_pkg::ST_EVAL: begin
        // Evaluation waits until the previous verdict has left the output register.
        if (!out_valid_r) begin
          state_nxt = stat.pre_done ? ipbf_pkg::ST_IDLE : ipbf_pkg::ST_LSCAN;
        end
      end
      ipbf_pkg::ST_LSCAN: begin
        if (stat.lst_match) begin
          state_nxt = ipbf_pkg::ST_RSCAN;
        end else if (stat.lst_end) begin
          state_nxt = ipbf_pkg::ST_IDLE;
        end
      end
      ipbf_pkg::ST_RSCAN: begin
        if (stat.rule_match || stat.rule_end) state_nxt = ipbf_pkg::ST_IDLE;
      end
      default: state_nxt = ipbf_pkg::ST_CLR;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd         = '0;
    cmd.res_sel = ipbf_pkg::RES_PRE;
    cmd.accept  = accept;
    unique case (state_r)
      ipbf_pkg::ST_CLR: begin
        cmd.clr_step = 1'b1;
      end
      ipbf_pkg::ST_IDLE: ;
      ipbf_pkg::ST_EVAL: begin
        cmd.scan_clr = 1'b1;
        if (stat.pre_done && !out_valid_r) begin
          cmd.out_load  = 1'b1;
          cmd.frame_clr = 1'b1;
        end
      end
      ipbf_pkg::ST_LSCAN: begin
        cmd.l_scan = 1'b1;
        if (stat.lst_end) begin
          cmd.out_load  = 1'b1;
          cmd.frame_clr = 1'b1;
          cmd.res_sel   = ipbf_pkg::RES_NOLST;
        end
      end
      ipbf_pkg::ST_RSCAN: begin
        cmd.r_scan = 1'b1;
        if (stat.rule_match) begin
          cmd.out_load  = 1'b1;
          cmd.frame_clr = 1'b1;
          cmd.res_sel   = ipbf_pkg::RES_RULE_HIT;
        end else if (stat.rule_end) begin
          cmd.out_load  = 1'b1;
          cmd.frame_clr = 1'b1;
          cmd.res_sel   = ipbf_pkg::RES_RULE_MISS;
        end
      end
      default: ;
    endcase
  end

  // Output valid flag: set when a verdict is loaded, cleared when the beat is taken.
  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipbf_pkg::ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A verdict is only ever loaded into an empty output register.
  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r)
    else $error("verdict loaded over a pending result");

  // No beat is taken while a verdict or the clearing pass is in progress.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ipbf_pkg::ST_IDLE |-> !in_ready)
    else $error("input ready outside idle");

  // The last byte of a frame always leads to evaluation.
  a_last_eval: assert property (@(posedge clk) disable iff (!rst_n)
    accept && stat.last_byte |=> state_r == ipbf_pkg::ST_EVAL)
    else $error("last byte did not start evaluation");

  // Table sweeps never run during the clearing pass.
  a_no_scan_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !cmd.l_scan && !cmd.r_scan && !out_valid_r)
    else $error("sweep or result during clearing pass");

endmodule
